[design/xlsu_pkg.sv]
// Shared types and constants for the x86 logic and shift unit.
// Depends on nothing; xlsu_datapath and x86_logic_shift_unit import it.
package xlsu_pkg;

  typedef enum logic [3:0] {
    OP_TEST  = 4'd0,
    OP_AND   = 4'd1,
    OP_XOR   = 4'd2,
    OP_OR    = 4'd3,
    OP_SAR   = 4'd4,
    OP_SHL   = 4'd5,
    OP_SHR   = 4'd6,
    OP_SETCC = 4'd7,
    OP_NOT   = 4'd8,
    OP_ROL   = 4'd9,
    OP_SHLD  = 4'd10,
    OP_SHRD  = 4'd11
  } op_t;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  // Condition groups selected by bits 3:1 of the condition code.
  localparam logic [2:0] CC_O  = 3'd0;
  localparam logic [2:0] CC_B  = 3'd1;
  localparam logic [2:0] CC_E  = 3'd2;
  localparam logic [2:0] CC_BE = 3'd3;
  localparam logic [2:0] CC_S  = 3'd4;
  localparam logic [2:0] CC_P  = 3'd5;
  localparam logic [2:0] CC_L  = 3'd6;
  localparam logic [2:0] CC_LE = 3'd7;

  typedef struct packed {
    logic cf;
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] dest_value;
    logic [31:0] src_value;
    logic [31:0] fill_value;
    logic [1:0]  size_code;
    logic [3:0]  cond_code;
    flags_t      flags;
    logic        pf;
  } req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_dest;
    flags_t      flags;
  } res_t;

endpackage

[design/xlsu_datapath.sv]
// Combinational datapath that computes the result and flags of one instruction.
// Depends on xlsu_pkg for the request, result and flag types.
module xlsu_datapath import xlsu_pkg::*; (
  input  req_t req,
  output res_t res
);

  logic [31:0] mask;
  logic [31:0] d;
  logic [31:0] rep;
  logic [31:0] sx;
  logic [4:0]  cnt;
  logic [63:0] rot_cat;
  logic [63:0] shl_cat;
  logic [63:0] shr_cat;
  logic [31:0] shld_r;
  logic [31:0] shrd_r;
  logic [31:0] raw;
  logic [31:0] r;
  logic        msb;
  logic        cond;
  logic        wr;
  logic        upd_zs;
  flags_t      fl;

  assign cnt = req.src_value[4:0];

  always_comb begin
    unique case (req.size_code)
      SZ_BYTE: begin
        mask    = 32'h0000_00ff;
        d       = {24'b0, req.dest_value[7:0]};
        rep     = {4{req.dest_value[7:0]}};
        sx      = {{24{req.dest_value[7]}}, req.dest_value[7:0]};
        shl_cat = {48'b0, req.dest_value[7:0], req.fill_value[7:0]} << cnt;
        shr_cat = {48'b0, req.fill_value[7:0], req.dest_value[7:0]} >> cnt;
        shld_r  = {24'b0, shl_cat[15:8]};
        shrd_r  = {24'b0, shr_cat[7:0]};
      end
      SZ_WORD: begin
        mask    = 32'h0000_ffff;
        d       = {16'b0, req.dest_value[15:0]};
        rep     = {2{req.dest_value[15:0]}};
        sx      = {{16{req.dest_value[15]}}, req.dest_value[15:0]};
        shl_cat = {32'b0, req.dest_value[15:0], req.fill_value[15:0]} << cnt;
        shr_cat = {32'b0, req.fill_value[15:0], req.dest_value[15:0]} >> cnt;
        shld_r  = {16'b0, shl_cat[31:16]};
        shrd_r  = {16'b0, shr_cat[15:0]};
      end
      default: begin
        mask    = 32'hffff_ffff;
        d       = req.dest_value;
        rep     = req.dest_value;
        sx      = req.dest_value;
        shl_cat = {req.dest_value, req.fill_value} << cnt;
        shr_cat = {req.fill_value, req.dest_value} >> cnt;
        shld_r  = shl_cat[63:32];
        shrd_r  = shr_cat[31:0];
      end
    endcase
  end

  // A replicated operand rotated at 32 bits equals a rotate at its own width.
  assign rot_cat = {rep, rep} << cnt;

  always_comb begin
    unique case (req.cond_code[3:1])
      CC_O:    cond = req.flags.of;
      CC_B:    cond = req.flags.cf;
      CC_E:    cond = req.flags.zf;
      CC_BE:   cond = req.flags.cf | req.flags.zf;
      CC_S:    cond = req.flags.sf;
      CC_P:    cond = req.pf;
      CC_L:    cond = req.flags.sf ^ req.flags.of;
      default: cond = req.flags.zf | (req.flags.sf ^ req.flags.of);
    endcase
    if (req.cond_code[0]) begin
      cond = ~cond;
    end
  end

  always_comb begin
    fl     = req.flags;
    wr     = 1'b1;
    upd_zs = 1'b1;
    unique case (req.operation)
      OP_TEST: begin
        raw   = d & req.src_value;
        wr    = 1'b0;
        fl.cf = 1'b0;
        fl.of = 1'b0;
      end
      OP_AND: begin
        raw   = d & req.src_value;
        fl.cf = 1'b0;
        fl.of = 1'b0;
      end
      OP_XOR: begin
        raw   = d ^ req.src_value;
        fl.cf = 1'b0;
        fl.of = 1'b0;
      end
      OP_OR: begin
        raw   = d | req.src_value;
        fl.cf = 1'b0;
        fl.of = 1'b0;
      end
      OP_SAR:   raw = $unsigned($signed(sx) >>> cnt);
      OP_SHL:   raw = d << cnt;
      OP_SHR:   raw = d >> cnt;
      OP_SETCC: begin
        raw    = {31'b0, cond};
        upd_zs = 1'b0;
      end
      OP_NOT: begin
        raw    = ~d;
        upd_zs = 1'b0;
      end
      OP_ROL:   raw = rot_cat[63:32];
      OP_SHLD:  raw = shld_r;
      OP_SHRD:  raw = shrd_r;
      default: begin
        raw    = 32'b0;
        wr     = 1'b0;
        upd_zs = 1'b0;
      end
    endcase
  end

  assign r = raw & mask;

  always_comb begin
    unique case (req.size_code)
      SZ_BYTE: msb = r[7];
      SZ_WORD: msb = r[15];
      default: msb = r[31];
    endcase
  end

  always_comb begin
    res.result     = r;
    res.write_dest = wr;
    res.flags      = fl;
    if (upd_zs) begin
      res.flags.zf = (r == 32'b0);
      res.flags.sf = msb;
    end
  end

endmodule

[design/x86_logic_shift_unit.sv]
// Path: an accepted input transaction passes the input register, then the result register, to the out_ ports.
// Throughput: one transaction per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result register is held.
// Reset: synchronous, active low on rst_n; both pipeline stages are emptied.
// Depends on xlsu_pkg and xlsu_datapath.
module x86_logic_shift_unit import xlsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [31:0] in_dest_value,
  input  logic [31:0] in_src_value,
  input  logic [31:0] in_fill_value,
  input  logic [1:0]  in_size_code,
  input  logic [3:0]  in_cond_code,
  input  logic        in_carry_in,
  input  logic        in_zero_in,
  input  logic        in_sign_in,
  input  logic        in_overflow_in,
  input  logic        in_parity_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result,
  output logic        out_write_dest,
  output logic        out_carry_out,
  output logic        out_zero_out,
  output logic        out_sign_out,
  output logic        out_overflow_out
);

  req_t req_r;
  req_t req_nxt;
  logic req_valid_r;
  res_t res_r;
  res_t res_nxt;
  logic res_valid_r;
  logic adv_out;
  logic adv_in;

  assign adv_out  = ~res_valid_r | ~out_stall;
  assign in_stall = req_valid_r & ~adv_out;
  assign adv_in   = in_valid & ~in_stall;

  always_comb begin
    req_nxt.operation   = op_t'(in_operation);
    req_nxt.dest_value  = in_dest_value;
    req_nxt.src_value   = in_src_value;
    req_nxt.fill_value  = in_fill_value;
    req_nxt.size_code   = in_size_code;
    req_nxt.cond_code   = in_cond_code;
    req_nxt.flags.cf    = in_carry_in;
    req_nxt.flags.zf    = in_zero_in;
    req_nxt.flags.sf    = in_sign_in;
    req_nxt.flags.of    = in_overflow_in;
    req_nxt.pf          = in_parity_in;
  end

  xlsu_datapath u_datapath (
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (adv_out) begin
        res_valid_r <= req_valid_r;
      end
      if (adv_in || adv_out) begin
        req_valid_r <= adv_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) begin
      req_r <= req_nxt;
    end
    if (adv_out && req_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_result       = res_r.result;
  assign out_write_dest   = res_r.write_dest;
  assign out_carry_out    = res_r.flags.cf;
  assign out_zero_out     = res_r.flags.zf;
  assign out_sign_out     = res_r.flags.sf;
  assign out_overflow_out = res_r.flags.of;

endmodule

[design/xlsu_checker.sv]
// Port-level checker for x86_logic_shift_unit, attached by the bind at the end.
// Depends only on the top level's ports.
module xlsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result,
  input logic        out_write_dest,
  input logic        out_carry_out,
  input logic        out_zero_out,
  input logic        out_overflow_out
);

  // An accepted transaction passes the input register, then the result register, to the output when not held.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted transaction did not reach the output");

  // A non-writing result with a nonzero value is a test: ZF, CF and OF are clear.
  a_test_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_dest && out_result != 32'b0)
      |-> (!out_zero_out && !out_carry_out && !out_overflow_out))
    else $error("test transaction has inconsistent flags");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result)))
    else $error("stalled output transaction changed");

endmodule

bind x86_logic_shift_unit xlsu_checker u_xlsu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result       (out_result),
  .out_write_dest   (out_write_dest),
  .out_carry_out    (out_carry_out),
  .out_zero_out     (out_zero_out),
  .out_overflow_out (out_overflow_out)
);

[test/tb.sv]
// Self-checking testbench for x86_logic_shift_unit: a directed instruction table, then random
// instructions under four handshake pressure phases, checked against table values or a local predictor.
// Depends on xlsu_pkg and the design files of the unit.
`timescale 1ns / 100ps

module tb;
  import xlsu_pkg::*;

  localparam logic [3:0] OP_SPARE_LO = 4'd12;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam logic [1:0] SZ_DWORD = 2'd2;
  localparam logic [1:0] SZ_ALT = 2'd3;
  localparam int RANDOM_PER_PHASE = 113;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] dest;
    logic [31:0] src;
    logic [31:0] fill;
    logic [1:0]  sz;
    logic [3:0]  cc;
    logic        cf;
    logic        zf;
    logic        sf;
    logic        of;
    logic        pf;
  } instr_t;

  typedef struct {
    instr_t ins;
    bit     known;
    res_t   want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_operation;
  logic [31:0] in_dest_value;
  logic [31:0] in_src_value;
  logic [31:0] in_fill_value;
  logic [1:0]  in_size_code;
  logic [3:0]  in_cond_code;
  logic        in_carry_in;
  logic        in_zero_in;
  logic        in_sign_in;
  logic        in_overflow_in;
  logic        in_parity_in;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result;
  logic        out_write_dest;
  logic        out_carry_out;
  logic        out_zero_out;
  logic        out_sign_out;
  logic        out_overflow_out;

  res_t pending_res[$];
  row_t plan[$];
  int   errs = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  bit   cur_known = 1'b0;
  res_t cur_want;

  x86_logic_shift_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_dest_value(in_dest_value),
    .in_src_value(in_src_value),
    .in_fill_value(in_fill_value),
    .in_size_code(in_size_code),
    .in_cond_code(in_cond_code),
    .in_carry_in(in_carry_in),
    .in_zero_in(in_zero_in),
    .in_sign_in(in_sign_in),
    .in_overflow_in(in_overflow_in),
    .in_parity_in(in_parity_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result(out_result),
    .out_write_dest(out_write_dest),
    .out_carry_out(out_carry_out),
    .out_zero_out(out_zero_out),
    .out_sign_out(out_sign_out),
    .out_overflow_out(out_overflow_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic res_t calc_alu(input instr_t t);
    int unsigned w;
    int unsigned k;
    logic [31:0] m;
    logic [31:0] d;
    logic [31:0] f;
    logic [31:0] r;
    logic [31:0] x;
    logic [63:0] cat;
    logic [4:0]  c;
    logic        hit;
    logic        upd;
    res_t        o;
    case (t.sz)
      SZ_BYTE: w = 8;
      SZ_WORD: w = 16;
      default: w = 32;
    endcase
    m = (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
    d = t.dest & m;
    f = t.fill & m;
    c = t.src[4:0];
    r = '0;
    upd = 1'b1;
    o.write_dest = 1'b1;
    o.flags.cf = t.cf;
    o.flags.zf = t.zf;
    o.flags.sf = t.sf;
    o.flags.of = t.of;
    case (t.op)
      OP_TEST: begin
        r = d & t.src;
        o.write_dest = 1'b0;
      end
      OP_AND: r = d & t.src;
      OP_XOR: r = d ^ t.src;
      OP_OR: r = d | t.src;
      OP_SAR: begin
        x = d;
        if (w < 32 && d[w - 1]) x = x | ~m;
        r = $signed(x) >>> c;
      end
      OP_SHL: r = d << c;
      OP_SHR: r = d >> c;
      OP_SETCC: begin
        upd = 1'b0;
        case (t.cc[3:1])
          CC_O: hit = t.of;
          CC_B: hit = t.cf;
          CC_E: hit = t.zf;
          CC_BE: hit = t.cf | t.zf;
          CC_S: hit = t.sf;
          CC_P: hit = t.pf;
          CC_L: hit = t.sf ^ t.of;
          default: hit = t.zf | (t.sf ^ t.of);
        endcase
        r = {31'b0, hit ^ t.cc[0]};
      end
      OP_NOT: begin
        upd = 1'b0;
        r = ~d;
      end
      OP_ROL: begin
        k = c % w;
        r = (k == 0) ? d : ((d << k) | (d >> (w - k)));
      end
      OP_SHLD: begin
        cat = ({32'b0, d} << w) | {32'b0, f};
        cat = (cat << c) >> w;
        r = cat[31:0];
      end
      OP_SHRD: begin
        cat = ({32'b0, f} << w) | {32'b0, d};
        cat = cat >> c;
        r = cat[31:0];
      end
      default: begin
        upd = 1'b0;
        o.write_dest = 1'b0;
      end
    endcase
    if (t.op <= OP_OR) begin
      o.flags.cf = 1'b0;
      o.flags.of = 1'b0;
    end
    r = r & m;
    if (upd) begin
      o.flags.zf = (r == 32'h0);
      o.flags.sf = r[w - 1];
    end
    o.result = r;
    return o;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t gen_instr();
    instr_t t;
    if ($urandom_range(99) < 6) t.op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    else t.op = 4'($urandom_range(OP_SHRD, OP_TEST));
    t.dest = pick_word();
    t.src = ($urandom_range(2) == 0) ? 32'($urandom_range(40)) : pick_word();
    t.fill = pick_word();
    t.sz = 2'($urandom_range(SZ_ALT, SZ_BYTE));
    t.cc = 4'($urandom_range(15));
    t.cf = 1'($urandom_range(1));
    t.zf = 1'($urandom_range(1));
    t.sf = 1'($urandom_range(1));
    t.of = 1'($urandom_range(1));
    t.pf = 1'($urandom_range(1));
    return t;
  endfunction

  // Input flags are packed {cf, zf, sf, of, pf}; typed results {write_dest, cf, zf, sf, of}.
  task automatic put_row(input logic [3:0] op, input logic [1:0] sz,
                         input logic [31:0] d, input logic [31:0] s, input logic [31:0] f,
                         input logic [3:0] cc, input logic [4:0] fl,
                         input bit known, input logic [31:0] er, input logic [4:0] ef);
    row_t row;
    row.ins.op = op;
    row.ins.sz = sz;
    row.ins.dest = d;
    row.ins.src = s;
    row.ins.fill = f;
    row.ins.cc = cc;
    {row.ins.cf, row.ins.zf, row.ins.sf, row.ins.of, row.ins.pf} = fl;
    row.known = known;
    row.want.result = er;
    row.want.write_dest = ef[4];
    row.want.flags = flags_t'(ef[3:0]);
    plan.push_back(row);
  endtask

  task automatic send_instr(input instr_t t, input bit known, input res_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_operation <= t.op;
    in_dest_value <= t.dest;
    in_src_value <= t.src;
    in_fill_value <= t.fill;
    in_size_code <= t.sz;
    in_cond_code <= t.cc;
    in_carry_in <= t.cf;
    in_zero_in <= t.zf;
    in_sign_in <= t.sf;
    in_overflow_in <= t.of;
    in_parity_in <= t.pf;
    cur_known = known;
    cur_want = want;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic cmp_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      errs++;
      if (errs <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, a);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    instr_t seen;
    res_t   want;
    bit     moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      moved = 1'b1;
      seen.op = in_operation;
      seen.dest = in_dest_value;
      seen.src = in_src_value;
      seen.fill = in_fill_value;
      seen.sz = in_size_code;
      seen.cc = in_cond_code;
      seen.cf = in_carry_in;
      seen.zf = in_zero_in;
      seen.sf = in_sign_in;
      seen.of = in_overflow_in;
      seen.pf = in_parity_in;
      if (cur_known) pending_res.push_back(cur_want);
      else pending_res.push_back(calc_alu(seen));
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (pending_res.size() == 0) begin
        errs++;
        if (errs <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none, actual result %h",
                   $time, out_result);
      end else begin
        want = pending_res.pop_front();
        cmp_field("result", want.result, out_result);
        cmp_field("write_dest", 32'(want.write_dest), 32'(out_write_dest));
        cmp_field("carry_out", 32'(want.flags.cf), 32'(out_carry_out));
        cmp_field("zero_out", 32'(want.flags.zf), 32'(out_zero_out));
        cmp_field("sign_out", 32'(want.flags.sf), 32'(out_sign_out));
        cmp_field("overflow_out", 32'(want.flags.of), 32'(out_overflow_out));
      end
    end
    if (moved || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int   idle_set[4];
    int   stall_set[4];
    res_t none;
    idle_set = '{0, 84, 0, 8};
    stall_set = '{0, 0, 84, 8};
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_TEST;
    in_dest_value = '0;
    in_src_value = '0;
    in_fill_value = '0;
    in_size_code = SZ_BYTE;
    in_cond_code = '0;
    in_carry_in = 1'b0;
    in_zero_in = 1'b0;
    in_sign_in = 1'b0;
    in_overflow_in = 1'b0;
    in_parity_in = 1'b0;
    cur_want = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    put_row(OP_AND, SZ_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0, 5'b11111,
            1'b1, 32'hFFFF_FFFF, 5'b10010);
    put_row(OP_TEST, SZ_BYTE, 32'h0000_00AA, 32'h0000_0055, 32'h0, 4'h0, 5'b10011,
            1'b1, 32'h0, 5'b00100);
    put_row(OP_XOR, SZ_WORD, 32'h0000_FFFF, 32'h0, 32'h0, 4'h0, 5'b00000,
            1'b1, 32'h0000_FFFF, 5'b10010);
    put_row(OP_OR, SZ_BYTE, 32'h0, 32'h0, 32'h0, 4'h0, 5'b00110,
            1'b1, 32'h0, 5'b10100);
    put_row(OP_SAR, SZ_BYTE, 32'h0000_0080, 32'd7, 32'h0, 4'h0, 5'b10010,
            1'b1, 32'h0000_00FF, 5'b11011);
    put_row(OP_SAR, SZ_DWORD, 32'h8000_0000, 32'd31, 32'h0, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SHL, SZ_DWORD, 32'h1, 32'd31, 32'h0, 4'h0, 5'b00000,
            1'b1, 32'h8000_0000, 5'b10010);
    put_row(OP_SHR, SZ_DWORD, 32'h8000_0000, 32'h3F, 32'h0, 4'h0, 5'b11111,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SHL, SZ_WORD, 32'h0000_1234, 32'd32, 32'h0, 4'h0, 5'b10101,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SETCC, SZ_BYTE, 32'h0, 32'h0, 32'h0, {CC_O, 1'b0}, 5'b00010,
            1'b1, 32'h1, 5'b10001);
    put_row(OP_SETCC, SZ_BYTE, 32'h0, 32'h0, 32'h0, {CC_E, 1'b1}, 5'b01000,
            1'b1, 32'h0, 5'b10100);
    put_row(OP_SETCC, SZ_BYTE, 32'h0, 32'h0, 32'h0, {CC_P, 1'b0}, 5'b00001,
            1'b1, 32'h1, 5'b10000);
    put_row(OP_SETCC, SZ_BYTE, 32'h0, 32'h0, 32'h0, {CC_LE, 1'b1}, 5'b00110,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SETCC, SZ_BYTE, 32'h0, 32'h0, 32'h0, {CC_L, 1'b0}, 5'b00100,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_NOT, SZ_BYTE, 32'h1234_560F, 32'h0, 32'h0, 4'h0, 5'b11111,
            1'b1, 32'h0000_00F0, 5'b11111);
    put_row(OP_ROL, SZ_BYTE, 32'h0000_0081, 32'd1, 32'h0, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_ROL, SZ_BYTE, 32'h0000_0081, 32'd8, 32'h0, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_ROL, SZ_DWORD, 32'hDEAD_BEEF, 32'd0, 32'h0, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SHLD, SZ_WORD, 32'h0000_1234, 32'd4, 32'h0000_ABCD, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SHLD, SZ_WORD, 32'h0000_1234, 32'd20, 32'h0000_ABCD, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SHRD, SZ_DWORD, 32'h1234_5678, 32'd0, 32'hFFFF_FFFF, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SHRD, SZ_BYTE, 32'h0000_00C3, 32'd12, 32'h0000_005A, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SHRD, SZ_DWORD, 32'h0, 32'd31, 32'hFFFF_FFFF, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);
    put_row(OP_SPARE_LO, SZ_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0, 5'b10101,
            1'b1, 32'h0, 5'b01010);
    put_row(OP_SPARE_HI, SZ_ALT, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0, 5'b01010,
            1'b1, 32'h0, 5'b00101);
    put_row(OP_AND, SZ_ALT, 32'h8000_00FF, 32'hF000_000F, 32'h0, 4'h0, 5'b00000,
            1'b0, 32'h0, 5'b00000);

    foreach (plan[i]) send_instr(plan[i].ins, plan[i].known, plan[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_instr(gen_instr(), 1'b0, none);
    end
    in_valid <= 1'b0;
    idle_pct = 0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errs == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
